>>> design/arpu_pkg.sv
// Shared constants and result word type for the API receive frame parser.
package arpu_pkg;

	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] RX16_TYPE = 8'h81;
	localparam logic [15:0] HEADER_LEN = 16'd5;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [15:0] source_address;
		logic [7:0]  payload_byte;
		logic [15:0] byte_index;
		logic        payload_last;
		logic [7:0]  frame_checksum;
	} arpu_result_t;

endpackage

>>> design/arpu_fsm.sv
// Frame parse state machine: one byte per step, zero or one result word.
module arpu_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	output arpu_pkg::arpu_result_t res
);

	typedef enum logic [3:0] {
		PH_HUNT   = 4'd0,
		PH_LEN_HI = 4'd1,
		PH_LEN_LO = 4'd2,
		PH_TYPE   = 4'd3,
		PH_SRC_HI = 4'd4,
		PH_SRC_LO = 4'd5,
		PH_RSSI   = 4'd6,
		PH_OPT    = 4'd7,
		PH_DATA   = 4'd8,
		PH_CSUM   = 4'd9
	} phase_t;

	phase_t      phase_q;
	logic [15:0] length_q;
	logic [15:0] count_q;
	logic [15:0] addr_q;

	logic [15:0] count_next;
	logic        last;

	assign count_next = count_q + 16'd1;
	assign last = (count_next >= length_q);

	always_comb begin
		res = '0;
		res.source_address = addr_q;
		case (phase_q)
			PH_DATA: begin
				res.valid = 1'b1;
				res.kind = arpu_pkg::KIND_PAYLOAD;
				res.payload_byte = rx_byte;
				res.byte_index = count_q;
				res.payload_last = last;
			end
			PH_CSUM: begin
				res.valid = 1'b1;
				res.kind = arpu_pkg::KIND_END;
				res.frame_checksum = rx_byte;
			end
			default: begin
				res.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			length_q <= '0;
			count_q <= '0;
			addr_q <= '0;
		end else if (step) begin
			case (phase_q)
				PH_LEN_HI: begin
					length_q <= {rx_byte, 8'h00};
					phase_q <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					length_q <= {length_q[15:8], rx_byte};
					phase_q <= PH_TYPE;
				end
				PH_TYPE: begin
					// other frame types: keep waiting, length untouched
					if (rx_byte == arpu_pkg::RX16_TYPE) begin
						if (length_q <= arpu_pkg::HEADER_LEN)
							length_q <= '0;
						else
							length_q <= length_q - arpu_pkg::HEADER_LEN;
						phase_q <= PH_SRC_HI;
					end
				end
				PH_SRC_HI: begin
					addr_q <= {rx_byte, 8'h00};
					phase_q <= PH_SRC_LO;
				end
				PH_SRC_LO: begin
					addr_q <= {addr_q[15:8], rx_byte};
					phase_q <= PH_RSSI;
				end
				PH_RSSI: begin
					phase_q <= PH_OPT;
				end
				PH_OPT: begin
					count_q <= '0;
					phase_q <= (length_q == '0) ? PH_CSUM : PH_DATA;
				end
				PH_DATA: begin
					if (last) begin
						count_q <= '0;
						phase_q <= PH_CSUM;
					end else begin
						count_q <= count_next;
					end
				end
				PH_CSUM: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= (rx_byte == arpu_pkg::START_BYTE) ? PH_LEN_HI : PH_HUNT;
				end
			endcase
		end
	end

endmodule

>>> design/api_frame_receive_parser_unit.sv
// Top level: input byte register, frame parser and output word register.
// A byte accepted into the input register drives the parser, and its result word is
// registered in the output word register, from which it can be taken.
// Throughput: one byte per cycle, bounded only by the output handshake.
// A byte that makes no word moves on even while a result word waits at the output.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// parser to start-byte hunting with length, count and address cleared.
module api_frame_receive_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [15:0] source_address,
	output logic [7:0]  payload_byte,
	output logic [15:0] byte_index,
	output logic        payload_last,
	output logic [7:0]  frame_checksum
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  advance;
	arpu_pkg::arpu_result_t res;
	arpu_pkg::arpu_result_t out_q;

	// byte in s1 moves on unless it makes a word and the output is blocked
	assign advance = valid_s1 && (!res.valid || !out_q.valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
	end

	arpu_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance && res.valid) begin
			out_q <= res;
		end else if (out_ready) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid = out_q.valid;
	assign kind = out_q.kind;
	assign source_address = out_q.source_address;
	assign payload_byte = out_q.payload_byte;
	assign byte_index = out_q.byte_index;
	assign payload_last = out_q.payload_last;
	assign frame_checksum = out_q.frame_checksum;

endmodule

>>> design/arpu_checker.sv
// Port-level assertions for the API receive frame parser, bound to the top level.
module arpu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [7:0]  rx_byte,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [15:0] source_address,
	input logic [7:0]  payload_byte,
	input logic [15:0] byte_index,
	input logic        payload_last,
	input logic [7:0]  frame_checksum
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) &&
		$stable(source_address) && $stable(payload_byte) && $stable(byte_index) &&
		$stable(payload_last) && $stable(frame_checksum))
		else $error("output word changed while stalled");

	// input backpressure only comes from a blocked output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with free output");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == arpu_pkg::KIND_END |->
		payload_byte == 8'h00 && byte_index == 16'h0000 && !payload_last)
		else $error("frame end word carries payload fields");

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == arpu_pkg::KIND_PAYLOAD |-> frame_checksum == 8'h00)
		else $error("payload word carries checksum");

endmodule

bind api_frame_receive_parser_unit arpu_checker u_arpu_checker (.*);
